FILE: sv/tbed_pkg.sv
// ----------------------------------------------------------------------------
// tbed_pkg
// Shared types, register map and reset values of the touch button event
// detector.
// ----------------------------------------------------------------------------
package tbed_pkg;

  // Baseline ring depth default
  localparam int WINDOW_DEF = 16;

  // Configuration register map, one 32-bit word per register
  localparam int CFG_NUM    = 8;
  localparam int CFG_IDX_W  = $clog2(CFG_NUM);
  localparam int CFG_ADDR_W = CFG_IDX_W + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_LONG       = 3'd1,
    REG_VERY_LONG  = 3'd2,
    REG_REPEAT     = 3'd3,
    REG_BEEP_DUR   = 3'd4,
    REG_THRESHOLD  = 3'd5,
    REG_PRESS_MODE = 3'd6,
    REG_BEEP_EN    = 3'd7
  } cfg_reg_e;

  // Press mode codes
  localparam logic [1:0] MODE_NONE      = 2'd0;
  localparam logic [1:0] MODE_REPEAT    = 2'd1;
  localparam logic [1:0] MODE_VERY_LONG = 2'd2;

  // Register reset values
  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [15:0] LONG_RST       = 16'd1000;
  localparam logic [15:0] VERY_LONG_RST  = 16'd5000;
  localparam logic [15:0] REPEAT_RST     = 16'd200;
  localparam logic [15:0] BEEP_DUR_RST   = 16'd100;
  localparam logic [7:0]  THRESHOLD_RST  = 8'd20;

  // Result word
  typedef struct packed {
    logic click_event;
    logic alternate_event;
    logic beep_level;
    logic pressed;
    logic raw_touch;
  } result_t;

endpackage

FILE: sv/touch_button_event_detector_unit.sv
// Output: a word's result is registered, shown the cycle after its accept.
// Throughput: one word per cycle unless a result stalls; the baseline ring
// entry for the next word is read ahead; the single read port never stalls.
// Reset: rst_ni clears all control state and restores the register defaults;
// the ring memory is not cleared, calibration writes every entry first.
// ----------------------------------------------------------------------------
// touch_button_event_detector_unit
// Capacitive touch button: baseline calibration, threshold classification,
// timestamp debounce, click, long-press repeat, very-long-press event, beep.
// ----------------------------------------------------------------------------
module touch_button_event_detector_unit
  import tbed_pkg::*;
#(
  parameter int WINDOW = WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  // Sample words
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [15:0]           sample_i,
  input  logic [31:0]           now_ms_i,

  // Result words
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  click_event_o,
  output logic                  alternate_event_o,
  output logic                  beep_level_o,
  output logic                  pressed_o,
  output logic                  raw_touch_o,

  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Ring index and running sum widths follow the window depth
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = 16 + IDX_W;
  localparam int CMP_W = SUM_W + 8;
  localparam logic [CMP_W-1:0] SCALE = CMP_W'(WINDOW * 16);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [15:0] debounce_q, long_q, very_long_q, repeat_q, beep_dur_q;
  logic [7:0]  threshold_q;
  logic [1:0]  press_mode_q;
  logic        beep_en_q;
  logic        cfg_wr;
  cfg_reg_e    cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_sel = cfg_reg_e'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= DEBOUNCE_RST;
      long_q       <= LONG_RST;
      very_long_q  <= VERY_LONG_RST;
      repeat_q     <= REPEAT_RST;
      beep_dur_q   <= BEEP_DUR_RST;
      threshold_q  <= THRESHOLD_RST;
      press_mode_q <= MODE_NONE;
      beep_en_q    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_DEBOUNCE:   debounce_q   <= pwdata[15:0];
        REG_LONG:       long_q       <= pwdata[15:0];
        REG_VERY_LONG:  very_long_q  <= pwdata[15:0];
        REG_REPEAT:     repeat_q     <= pwdata[15:0];
        REG_BEEP_DUR:   beep_dur_q   <= pwdata[15:0];
        REG_THRESHOLD:  threshold_q  <= pwdata[7:0];
        REG_PRESS_MODE: press_mode_q <= pwdata[1:0];
        REG_BEEP_EN:    beep_en_q    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the selected register, zero-extended
  always_comb begin
    unique case (cfg_sel)
      REG_DEBOUNCE:   prdata = {16'd0, debounce_q};
      REG_LONG:       prdata = {16'd0, long_q};
      REG_VERY_LONG:  prdata = {16'd0, very_long_q};
      REG_REPEAT:     prdata = {16'd0, repeat_q};
      REG_BEEP_DUR:   prdata = {16'd0, beep_dur_q};
      REG_THRESHOLD:  prdata = {24'd0, threshold_q};
      REG_PRESS_MODE: prdata = {30'd0, press_mode_q};
      REG_BEEP_EN:    prdata = {31'd0, beep_en_q};
      default:        prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: the output register parts the two sides. A new word enters
  // whenever the result register is empty or drains in this cycle.
  // --------------------------------------------------------------------------
  logic    accept;
  logic    out_valid_q;
  result_t res_d, res_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // --------------------------------------------------------------------------
  // Baseline ring memory. The entry at the next ring index is read every
  // cycle, so rd_data_q always holds the entry the next sample replaces.
  // A write goes to the current index and the index then moves on, so a
  // read never targets the entry written in the same cycle.
  // --------------------------------------------------------------------------
  logic [15:0]      ring_mem [WINDOW];
  logic [15:0]      rd_data_q;
  logic             ring_we;
  logic [IDX_W-1:0] ring_idx_q, ring_idx_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             calib_q, calib_d;

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_idx_q] <= sample_i;
    end
    rd_data_q <= ring_mem[ring_idx_d];
  end

  // --------------------------------------------------------------------------
  // Classification: calibrate first, then compare sample*WINDOW*16 against
  // baseline_sum*threshold. Untouched samples refresh the baseline.
  // --------------------------------------------------------------------------
  logic [CMP_W-1:0] lhs, rhs;
  logic             touched;
  logic             raw;
  logic [IDX_W-1:0] idx_inc;

  assign lhs     = CMP_W'(sample_i) * SCALE;
  assign rhs     = CMP_W'(sum_q) * CMP_W'(threshold_q);
  assign touched = lhs > rhs;
  assign idx_inc = (ring_idx_q == IDX_LAST) ? '0 : ring_idx_q + IDX_W'(1);

  always_comb begin
    ring_we    = 1'b0;
    ring_idx_d = ring_idx_q;
    sum_d      = sum_q;
    calib_d    = calib_q;
    raw        = 1'b0;
    if (!calib_q) begin
      // Fill the ring; the last entry completes calibration
      ring_we    = accept;
      if (accept) begin
        sum_d      = sum_q + SUM_W'(sample_i);
        ring_idx_d = idx_inc;
        calib_d    = (ring_idx_q == IDX_LAST);
      end
    end else begin
      raw = touched;
      if (accept && !touched) begin
        ring_we    = 1'b1;
        sum_d      = sum_q - SUM_W'(rd_data_q) + SUM_W'(sample_i);
        ring_idx_d = idx_inc;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Debounce and press timing. All age compares use the stored times; a
  // timestamp taken in this word gives age zero, which the enables cover.
  // --------------------------------------------------------------------------
  logic        last_raw_q, stable_q, beep_q;
  logic [31:0] raw_chg_time_q, press_start_q, last_rep_q, beep_start_q;
  logic [31:0] raw_age, press_age, rep_age, beep_age;
  logic        raw_chg, stable_chg, rise, fall, held, rep_click;
  logic        alt_evt, beep_d, beep_set;

  assign raw_age   = now_ms_i - raw_chg_time_q;
  assign press_age = now_ms_i - press_start_q;
  assign rep_age   = now_ms_i - last_rep_q;
  assign beep_age  = now_ms_i - beep_start_q;

  assign raw_chg    = raw != last_raw_q;
  assign stable_chg = !raw_chg && (raw_age > 32'(debounce_q)) && (raw != stable_q);
  assign rise       = stable_chg & raw;
  assign fall       = stable_chg & ~raw;
  // Press still held from an earlier word
  assign held       = stable_q & ~stable_chg;

  assign rep_click  = (press_mode_q == MODE_REPEAT) && held &&
                      (press_age > 32'(long_q)) && (rep_age >= 32'(repeat_q));
  assign alt_evt    = (press_mode_q == MODE_VERY_LONG) && held &&
                      (press_age > 32'(very_long_q));

  // Start the beep on a new press; a running pulse ends after its duration
  assign beep_set   = rise & beep_en_q;
  assign beep_d     = beep_set | (beep_q & ~(beep_age > 32'(beep_dur_q)));

  always_comb begin
    res_d.click_event     = rise | rep_click;
    res_d.alternate_event = alt_evt;
    res_d.beep_level      = beep_d & beep_en_q;
    res_d.pressed         = stable_chg ? raw : stable_q;
    res_d.raw_touch       = raw;
  end

  // Control and timing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_idx_q     <= '0;
      sum_q          <= '0;
      calib_q        <= 1'b0;
      last_raw_q     <= 1'b0;
      raw_chg_time_q <= '0;
      stable_q       <= 1'b0;
      press_start_q  <= '0;
      last_rep_q     <= '0;
      beep_start_q   <= '0;
      beep_q         <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (accept) begin
        ring_idx_q <= ring_idx_d;
        sum_q      <= sum_d;
        calib_q    <= calib_d;
        last_raw_q <= raw;
        if (raw_chg) begin
          raw_chg_time_q <= now_ms_i;
        end
        stable_q <= res_d.pressed;
        if (rise) begin
          press_start_q <= now_ms_i;
        end else if (fall) begin
          press_start_q <= '0;
        end
        if (fall) begin
          last_rep_q <= '0;
        end else if (rep_click) begin
          last_rep_q <= now_ms_i;
        end
        if (beep_set) begin
          beep_start_q <= now_ms_i;
        end
        beep_q <= beep_d;
      end
      // Hold the result until taken
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign click_event_o     = res_q.click_event;
  assign alternate_event_o = res_q.alternate_event;
  assign beep_level_o      = res_q.beep_level;
  assign pressed_o         = res_q.pressed;
  assign raw_touch_o       = res_q.raw_touch;

endmodule

FILE: verif/touch_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_event_checker
// Watches the sample, result and configuration ports of the touch button
// event detector, predicts every result word and compares it field by field.
// ----------------------------------------------------------------------------
module touch_event_checker
  import tbed_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  word_valid_i,
  input  logic                  word_stall_i,
  input  logic [15:0]           sample_i,
  input  logic [31:0]           now_ms_i,

  input  logic                  result_valid_i,
  input  logic                  result_stall_i,
  input  logic                  click_event_i,
  input  logic                  alternate_event_i,
  input  logic                  beep_level_i,
  input  logic                  pressed_i,
  input  logic                  raw_touch_i,

  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  input  logic                  pready,

  output int                    mismatch_count_o,
  output int                    pending_o
);

  localparam int WIN = WINDOW_DEF;

  // Register copies
  logic [15:0] settle_time, hold_time, very_long_ms, repeat_gap, beep_dur_ms;
  logic [7:0]  threshold;
  logic [1:0]  press_mode;
  logic        beep_en;

  // Detector state
  logic [15:0] baseline_ring [WIN];
  logic [19:0] baseline_sum;
  int          ring_pos;
  logic        calibrated;
  logic        last_raw;
  logic [31:0] raw_change_ms;
  logic        stable_press;
  logic [31:0] press_start_ms;
  logic [31:0] last_repeat_ms;
  logic [31:0] beep_start_ms;
  logic        beep_on;

  result_t     expected_results [$];

  // Advance the detector by one sample word and return its result word.
  task automatic track_touch_sample(input logic [15:0] s, input logic [31:0] t,
                                    output result_t r);
    logic        raw;
    logic        click;
    logic        alt;
    logic [63:0] level;
    logic [63:0] limit;
    raw   = 1'b0;
    click = 1'b0;
    alt   = 1'b0;

    // Classify: fill the ring first, then compare against the baseline
    if (!calibrated) begin
      baseline_ring[ring_pos] = s;
      baseline_sum = baseline_sum + 20'(s);
      if (ring_pos == WIN - 1) calibrated = 1'b1;
      ring_pos = (ring_pos + 1) % WIN;
    end else begin
      level = 64'(s) * WIN * 16;
      limit = 64'(baseline_sum) * 64'(threshold);
      if (level > limit) begin
        raw = 1'b1;
      end else begin
        baseline_sum = baseline_sum - 20'(baseline_ring[ring_pos]) + 20'(s);
        baseline_ring[ring_pos] = s;
        ring_pos = (ring_pos + 1) % WIN;
      end
    end

    if (raw != last_raw) begin
      last_raw      = raw;
      raw_change_ms = t;
    end

    // Debounce on the timestamp; all differences wrap at 32 bits
    if (32'(t - raw_change_ms) > 32'(settle_time) && last_raw != stable_press) begin
      stable_press = last_raw;
      if (stable_press) begin
        if (beep_en) begin
          beep_on       = 1'b1;
          beep_start_ms = t;
        end
        click          = 1'b1;
        press_start_ms = t;
      end else begin
        press_start_ms = '0;
        last_repeat_ms = '0;
      end
    end

    if (press_mode == MODE_REPEAT && stable_press &&
        32'(t - press_start_ms) > 32'(hold_time)) begin
      if (32'(t - last_repeat_ms) >= 32'(repeat_gap)) begin
        click          = 1'b1;
        last_repeat_ms = t;
      end
    end

    if (press_mode == MODE_VERY_LONG && stable_press &&
        32'(t - press_start_ms) > 32'(very_long_ms))
      alt = 1'b1;

    if (beep_on && 32'(t - beep_start_ms) > 32'(beep_dur_ms)) beep_on = 1'b0;

    r.click_event     = click;
    r.alternate_event = alt;
    r.beep_level      = beep_on & beep_en;
    r.pressed         = stable_press;
    r.raw_touch       = raw;
  endtask

  task automatic check_field(input string name, input logic exp_bit, input logic act_bit);
    if (act_bit !== exp_bit) begin
      $display("%0t ns: %s mismatch, expected %0b actual %0b", $time, name, exp_bit,
               act_bit);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t predicted;
    result_t oldest;
    if (!rst_ni) begin
      settle_time    = DEBOUNCE_RST;
      hold_time      = LONG_RST;
      very_long_ms   = VERY_LONG_RST;
      repeat_gap     = REPEAT_RST;
      beep_dur_ms    = BEEP_DUR_RST;
      threshold      = THRESHOLD_RST;
      press_mode     = MODE_NONE;
      beep_en        = 1'b0;
      for (int i = 0; i < WIN; i++) baseline_ring[i] = '0;
      baseline_sum   = '0;
      ring_pos       = 0;
      calibrated     = 1'b0;
      last_raw       = 1'b0;
      raw_change_ms  = '0;
      stable_press   = 1'b0;
      press_start_ms = '0;
      last_repeat_ms = '0;
      beep_start_ms  = '0;
      beep_on        = 1'b0;
      expected_results.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      // Compare the result word leaving the block with the oldest prediction
      if (result_valid_i && !result_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t ns: result word with no prediction pending", $time);
          mismatch_count_o++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("click_event", oldest.click_event, click_event_i);
          check_field("alternate_event", oldest.alternate_event, alternate_event_i);
          check_field("beep_level", oldest.beep_level, beep_level_i);
          check_field("pressed", oldest.pressed, pressed_i);
          check_field("raw_touch", oldest.raw_touch, raw_touch_i);
        end
      end

      if (word_valid_i && !word_stall_i) begin
        track_touch_sample(sample_i, now_ms_i, predicted);
        expected_results.push_back(predicted);
      end

      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[CFG_ADDR_W-1:2]))
          REG_DEBOUNCE:   settle_time   = pwdata[15:0];
          REG_LONG:       hold_time     = pwdata[15:0];
          REG_VERY_LONG:  very_long_ms  = pwdata[15:0];
          REG_REPEAT:     repeat_gap    = pwdata[15:0];
          REG_BEEP_DUR:   beep_dur_ms   = pwdata[15:0];
          REG_THRESHOLD:  threshold     = pwdata[7:0];
          REG_PRESS_MODE: press_mode    = pwdata[1:0];
          REG_BEEP_EN:    beep_en       = pwdata[0];
          default: ;
        endcase
      end

      pending_o = expected_results.size();
    end
  end

endmodule

FILE: verif/touch_button_event_detector_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_button_event_detector_unit_tb
// Drives sample words and register writes into the touch button event
// detector through calibration, directed presses across the time wrap and
// random press/release phases under several register settings, with bursty
// input and a stalling receiver; the checker beside the block judges each
// result word.
// ----------------------------------------------------------------------------
module touch_button_event_detector_unit_tb;
  import tbed_pkg::*;

  // Press mode code with no meaning of its own; the block treats it as none
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;

  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [15:0]           sample_i;
  logic [31:0]           now_ms_i;

  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  click_event_o;
  logic                  alternate_event_o;
  logic                  beep_level_o;
  logic                  pressed_o;
  logic                  raw_touch_o;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  int                    mismatch_count;
  int                    results_pending;

  // Sender burst bookkeeping and the running millisecond clock of the button
  int                    burst_left = 4;
  logic [31:0]           now_cursor;

  // Receiver stall pattern
  int                    stall_left = 0;

  always #6 clk_i = ~clk_i;

  touch_button_event_detector_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_i          (sample_i),
    .now_ms_i          (now_ms_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .click_event_o     (click_event_o),
    .alternate_event_o (alternate_event_o),
    .beep_level_o      (beep_level_o),
    .pressed_o         (pressed_o),
    .raw_touch_o       (raw_touch_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  touch_event_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .word_valid_i      (in_valid_i),
    .word_stall_i      (in_stall_o),
    .sample_i          (sample_i),
    .now_ms_i          (now_ms_i),
    .result_valid_i    (out_valid_o),
    .result_stall_i    (out_stall_i),
    .click_event_i     (click_event_o),
    .alternate_event_i (alternate_event_o),
    .beep_level_i      (beep_level_o),
    .pressed_i         (pressed_o),
    .raw_touch_i       (raw_touch_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .mismatch_count_o  (mismatch_count),
    .pending_o         (results_pending)
  );

  // Stall the result side in short random runs, with long quiet stretches
  // mixed in so back-to-back results also get through.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          out_stall_i <= 1'b1;
          stall_left  <= $urandom_range(0, 4);
        end
        3: begin
          out_stall_i <= 1'b0;
          stall_left  <= $urandom_range(20, 60);
        end
        default: begin
          out_stall_i <= 1'b0;
          stall_left  <= $urandom_range(0, 5);
        end
      endcase
    end
  end

  // Hand one sample word over and hold it until the block takes it. Drop
  // valid for a random gap whenever the current burst runs out.
  task automatic send_word(input logic [15:0] s, input logic [31:0] t);
    in_valid_i <= 1'b1;
    sample_i   <= s;
    now_ms_i   <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // that sees pready with penable.
  task automatic cfg_write(input cfg_reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending, let every predicted result drain, then rewrite all registers.
  task automatic configure(input logic [15:0] debounce, input logic [15:0] long_press,
                           input logic [15:0] very_long, input logic [15:0] rep,
                           input logic [15:0] beep_dur, input logic [7:0] thr,
                           input logic [1:0] mode, input logic beep_on);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_write(REG_DEBOUNCE,   32'(debounce));
    cfg_write(REG_LONG,       32'(long_press));
    cfg_write(REG_VERY_LONG,  32'(very_long));
    cfg_write(REG_REPEAT,     32'(rep));
    cfg_write(REG_BEEP_DUR,   32'(beep_dur));
    cfg_write(REG_THRESHOLD,  32'(thr));
    cfg_write(REG_PRESS_MODE, 32'(mode));
    cfg_write(REG_BEEP_EN,    32'(beep_on));
  endtask

  // Alternate press and release episodes of random length. Presses carry
  // the odd bounce, any word may be full-range noise, and the clock now and
  // then jumps to a random point so it wraps and runs backward too.
  task automatic run_press_phase(input int n_words, input int step_max, input int base_lvl);
    int          sent;
    int          hold;
    bit          touching;
    logic [15:0] s;
    sent     = 0;
    touching = 1'b0;
    while (sent < n_words) begin
      if (touching)
        hold = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 25);
      else
        hold = $urandom_range(1, 15);
      repeat (hold) begin
        if ($urandom_range(0, 29) == 0)
          s = 16'($urandom_range(0, 65535));
        else if (touching && $urandom_range(0, 9) != 0)
          s = 16'($urandom_range(60000, 65535));
        else
          s = 16'(base_lvl + $urandom_range(0, base_lvl / 8));
        if ($urandom_range(0, 39) == 0)
          now_cursor = $urandom();
        else
          now_cursor = now_cursor + 32'($urandom_range(0, step_max));
        send_word(s, now_cursor);
        sent++;
      end
      touching = !touching;
    end
  endtask

  initial begin : watchdog
    #2_000_000;
    $display("touch_button_event_detector_unit_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    int drain;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    sample_i    <= '0;
    now_ms_i    <= '0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: short debounce, repeat clicks and beep on
    configure(16'd5, 16'd60, 16'd120, 16'd15, 16'd30, 8'd20, MODE_REPEAT, 1'b1);

    // Calibrate with both sample extremes in the baseline
    for (int i = 0; i < 16; i++) begin
      if (i == 0)
        send_word(16'h0000, 32'hFFFF_FF00);
      else if (i == 1)
        send_word(16'hFFFF, 32'hFFFF_FF08);
      else
        send_word(16'(900 + 10 * i), 32'hFFFF_FF00 + 32'(8 * i));
    end

    // Press that settles across the clock wrap, so the click and the beep
    // start at time zero; hold past the long-press age for repeat clicks,
    // then release and let the beep run out.
    send_word(16'd60000, 32'hFFFF_FFFA);
    send_word(16'd60000, 32'd0);
    send_word(16'd61000, 32'd20);
    send_word(16'd62000, 32'd40);
    send_word(16'd63000, 32'd70);
    send_word(16'hFFFF,  32'd90);
    send_word(16'd1000,  32'd95);
    send_word(16'd1000,  32'd96);
    send_word(16'd1000,  32'd110);

    // Every register at its maximum, very-long-press mode, large time steps
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, MODE_VERY_LONG, 1'b1);
    now_cursor = $urandom();
    run_press_phase(80, 5000, 500);

    // Every register at zero: any nonzero sample reads as touched
    configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 8'd0, MODE_NONE, 1'b0);
    run_press_phase(60, 3, 300);

    // Unused press mode must act as no mode
    configure(16'd10, 16'd150, 16'd300, 16'd20, 16'd40, 8'd24, MODE_UNUSED, 1'b1);
    now_cursor = 32'hFFFF_F000;
    run_press_phase(70, 15, 1000);

    // Random settings; beep enable flips between phases and may cut a pulse
    repeat (6) begin
      configure(16'($urandom_range(0, 40)), 16'($urandom_range(0, 300)),
                16'($urandom_range(0, 600)), 16'($urandom_range(0, 60)),
                16'($urandom_range(0, 100)),
                ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(17, 48)),
                2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 1) == 0) now_cursor = $urandom();
      run_press_phase(75, $urandom_range(1, 30), $urandom_range(200, 3000));
    end

    // Drain what is still in flight, then give the pipe a few more edges
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    drain = 0;
    while (results_pending != 0 && drain < 5000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (4) @(posedge clk_i);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("touch_button_event_detector_unit_tb: PASS");
    end else begin
      if (results_pending != 0)
        $display("%0t ns: %0d predicted results never arrived", $time, results_pending);
      $display("touch_button_event_detector_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tbed_pkg.sv
sv/touch_button_event_detector_unit.sv
verif/touch_event_checker.sv
verif/touch_button_event_detector_unit_tb.sv
